@@ sv/lobm_pkg.sv @@
// Package: types, constants and codes shared by the order book matcher.
package lobm_pkg;

  localparam int unsigned BookDepth = 16;
  localparam int unsigned SlotW     = $clog2(BookDepth);
  localparam int unsigned CntW      = $clog2(BookDepth + 1);
  localparam int unsigned MaxFills  = 16;
  localparam int unsigned FillW     = $clog2(MaxFills + 1);

  // Order side and kind, result kind.
  localparam logic SideBuy    = 1'b0;
  localparam logic SideSell   = 1'b1;
  localparam logic KindLimit  = 1'b0;
  localparam logic KindMarket = 1'b1;
  localparam logic KindFill   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [2:0] {
    StPending   = 3'd0,
    StPartial   = 3'd1,
    StFilled    = 3'd2,
    StCancelled = 3'd3,
    StRejected  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_FREE,
    S_STATUS,
    S_OUT
  } state_e;

  typedef struct packed {
    logic        side;
    logic        order_kind;
    logic [31:0] limit_price;
    logic [31:0] quantity;
    logic [15:0] order_tag;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] taker_tag;
    logic [15:0] maker_tag;
    logic [31:0] exec_price;
    logic [31:0] fill_qty;
    logic [31:0] maker_left;
    logic [2:0]  final_status;
    logic        last_result;
  } out_word_t;

endpackage

@@ sv/limit_order_book_matcher.sv @@
// Top level: price-time priority matcher over a bounded book of resting orders.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+----------------------------------
//  in      | in  | in_valid_i / in_ready_o   | in_word_i  (lobm_pkg::in_word_t)
//  out     | out | out_valid_o / out_ready_i | out_word_o (lobm_pkg::out_word_t)
//
// Each fill is a full scan of the book, one slot a cycle through a single shared
// compare unit, then the fill state and the output state.
// Each further fill repeats the scan, and a limit remainder is followed by a
// search for a free slot, in which it rests if one is found.
// Reset clears all slot valid bits and the arrival counter; slot payload
// stays undefined until written. Stalls on the output hold the word in the
// output register; no new order is taken until the status word has left.
module limit_order_book_matcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lobm_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lobm_pkg::out_word_t  out_word_o
);

  localparam int unsigned SW = lobm_pkg::SlotW;

  // Book storage: valid bits reset, payload does not.
  logic [lobm_pkg::BookDepth-1:0] valid_q, valid_d;
  logic        slot_side_q    [lobm_pkg::BookDepth];
  logic [31:0] slot_price_q   [lobm_pkg::BookDepth];
  logic [31:0] slot_left_q    [lobm_pkg::BookDepth];
  logic [15:0] slot_tag_q     [lobm_pkg::BookDepth];
  logic [31:0] slot_arrival_q [lobm_pkg::BookDepth];

  logic [31:0] arrival_q, arrival_d;

  lobm_pkg::state_e state_q, state_d;
  lobm_pkg::in_word_t ord_q, ord_d;
  logic [31:0] remaining_q, remaining_d;
  logic [31:0] filled_q, filled_d;
  logic [lobm_pkg::FillW-1:0] nfill_q, nfill_d;
  logic [lobm_pkg::CntW-1:0]  idx_q, idx_d;
  logic        best_ok_q, best_ok_d;
  logic [SW-1:0] best_q, best_d;
  logic [31:0] best_price_q, best_price_d;
  logic [31:0] best_age_q, best_age_d;
  lobm_pkg::out_word_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  lobm_pkg::status_e status_q, status_d;

  // Shared compare unit: looks at slot idx_q each scan cycle.
  logic [SW-1:0] cur;
  logic [31:0]   cur_price, cur_age, fill_amt, left_after;
  logic          cand, better;

  assign cur       = idx_q[SW-1:0];
  assign cur_price = slot_price_q[cur];
  assign cur_age   = arrival_q - slot_arrival_q[cur];

  always_comb begin
    cand = valid_q[cur] && (slot_side_q[cur] != ord_q.side);
    if (!ord_q.order_kind) begin
      if (!ord_q.side && cur_price > ord_q.limit_price) cand = 1'b0;
      if (ord_q.side && cur_price < ord_q.limit_price) cand = 1'b0;
    end
    if (!best_ok_q) begin
      better = 1'b1;
    end else if (cur_price == best_price_q) begin
      better = cur_age > best_age_q;
    end else begin
      better = ord_q.side ? (cur_price > best_price_q) : (cur_price < best_price_q);
    end
  end

  assign fill_amt   = (remaining_q < slot_left_q[best_q]) ? remaining_q
                                                          : slot_left_q[best_q];
  assign left_after = slot_left_q[best_q] - fill_amt;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lobm_pkg::S_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          state_d = (in_word_i.quantity == '0) ? lobm_pkg::S_STATUS : lobm_pkg::S_SCAN;
        end
      end
      lobm_pkg::S_SCAN: begin
        if (idx_q == lobm_pkg::CntW'(lobm_pkg::BookDepth - 1)) begin
          if (best_ok_q || (cand && better)) begin
            state_d = lobm_pkg::S_FILL;
          end else if (ord_q.order_kind) begin
            state_d = lobm_pkg::S_STATUS;
          end else begin
            state_d = lobm_pkg::S_FREE;
          end
        end
      end
      lobm_pkg::S_FILL: begin
        if (!out_valid_q) begin
          state_d = lobm_pkg::S_OUT;
        end
      end
      lobm_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          if (remaining_q == '0 ||
              nfill_q == lobm_pkg::FillW'(lobm_pkg::MaxFills)) begin
            state_d = (remaining_q == '0 || ord_q.order_kind) ? lobm_pkg::S_STATUS
                                                              : lobm_pkg::S_FREE;
          end else begin
            state_d = lobm_pkg::S_SCAN;
          end
        end
      end
      lobm_pkg::S_FREE: begin
        if (!valid_q[cur] || idx_q == lobm_pkg::CntW'(lobm_pkg::BookDepth - 1)) begin
          state_d = lobm_pkg::S_STATUS;
        end
      end
      lobm_pkg::S_STATUS: begin
        if (!out_valid_q) begin
          state_d = lobm_pkg::S_IDLE;
        end
      end
      default: state_d = lobm_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    ord_d        = ord_q;
    remaining_d  = remaining_q;
    filled_d     = filled_q;
    nfill_d      = nfill_q;
    idx_d        = idx_q;
    best_ok_d    = best_ok_q;
    best_d       = best_q;
    best_price_d = best_price_q;
    best_age_d   = best_age_q;
    valid_d      = valid_q;
    arrival_d    = arrival_q;
    status_d     = status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    unique case (state_q)
      lobm_pkg::S_IDLE: begin
        in_ready_o  = !out_valid_q;
        ord_d       = in_word_i;
        remaining_d = in_word_i.quantity;
        filled_d    = '0;
        nfill_d     = '0;
        idx_d       = '0;
        best_ok_d   = 1'b0;
        status_d    = lobm_pkg::StCancelled;
      end
      lobm_pkg::S_SCAN: begin
        if (cand && better) begin
          best_ok_d    = 1'b1;
          best_d       = cur;
          best_price_d = cur_price;
          best_age_d   = cur_age;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == lobm_pkg::CntW'(lobm_pkg::BookDepth - 1)) begin
          idx_d = '0;
          if (!(best_ok_q || (cand && better))) begin
            status_d = ord_q.order_kind ? lobm_pkg::StCancelled : lobm_pkg::StRejected;
          end
        end
      end
      lobm_pkg::S_FILL: begin
        // Wait for the output register, then emit the fill and update the maker.
        if (!out_valid_q) begin
          out_valid_d        = 1'b1;
          out_d.result_kind  = lobm_pkg::KindFill;
          out_d.taker_tag    = ord_q.order_tag;
          out_d.maker_tag    = slot_tag_q[best_q];
          out_d.exec_price   = slot_price_q[best_q];
          out_d.fill_qty     = fill_amt;
          out_d.maker_left   = left_after;
          out_d.final_status = lobm_pkg::StPending;
          out_d.last_result  = 1'b0;
          remaining_d        = remaining_q - fill_amt;
          filled_d           = filled_q + fill_amt;
          nfill_d            = nfill_q + 1'b1;
          if (left_after == '0) valid_d[best_q] = 1'b0;
        end
      end
      lobm_pkg::S_OUT: begin
        best_ok_d = 1'b0;
        idx_d     = '0;
        if (remaining_q == '0) begin
          status_d = lobm_pkg::StFilled;
        end else begin
          status_d = ord_q.order_kind ? lobm_pkg::StCancelled : lobm_pkg::StRejected;
        end
      end
      lobm_pkg::S_FREE: begin
        idx_d = idx_q + 1'b1;
        if (!valid_q[cur]) begin
          valid_d[cur] = 1'b1;
          arrival_d    = arrival_q + 1'b1;
          status_d     = (filled_q != '0) ? lobm_pkg::StPartial : lobm_pkg::StPending;
        end
      end
      lobm_pkg::S_STATUS: begin
        if (!out_valid_q) begin
          out_valid_d        = 1'b1;
          out_d.result_kind  = lobm_pkg::KindStatus;
          out_d.taker_tag    = ord_q.order_tag;
          out_d.maker_tag    = '0;
          out_d.exec_price   = '0;
          out_d.fill_qty     = filled_q;
          out_d.maker_left   = '0;
          out_d.final_status = status_q;
          out_d.last_result  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Slot payload writes: fill updates the maker, rest writes a free slot.
  always_ff @(posedge clk_i) begin
    if (state_q == lobm_pkg::S_FILL && !out_valid_q) begin
      slot_left_q[best_q] <= left_after;
    end
    if (state_q == lobm_pkg::S_FREE && !valid_q[cur]) begin
      slot_side_q[cur]    <= ord_q.side;
      slot_price_q[cur]   <= ord_q.limit_price;
      slot_left_q[cur]    <= remaining_q;
      slot_tag_q[cur]     <= ord_q.order_tag;
      slot_arrival_q[cur] <= arrival_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lobm_pkg::S_IDLE;
      valid_q     <= '0;
      arrival_q   <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      best_ok_q   <= 1'b0;
      nfill_q     <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      arrival_q   <= arrival_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      best_ok_q   <= best_ok_d;
      nfill_q     <= nfill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ord_q        <= ord_d;
    remaining_q  <= remaining_d;
    filled_q     <= filled_d;
    best_q       <= best_d;
    best_price_q <= best_price_d;
    best_age_q   <= best_age_d;
    out_q        <= out_d;
    status_q     <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
